### sv/lobm_pkg.sv
// Shared types, constants and helpers for the limit order book matcher.
// No dependencies; the interfaces, the matcher and the bench files import this package.
package lobm_pkg;

   localparam int BOOK_DEPTH = 32;
   localparam int AW = $clog2(BOOK_DEPTH);
   localparam int CW = $clog2(BOOK_DEPTH + 1);

   localparam int PRICE_W = 20;
   localparam int ID_W    = 32;
   localparam int QTY_W   = 16;

   localparam logic OP_BUY  = 1'b0;
   localparam logic OP_SELL = 1'b1;

   localparam logic SIDE_BID = 1'b0;
   localparam logic SIDE_ASK = 1'b1;

   localparam logic KIND_TRADE   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_ZERO = 2'd2;

   typedef struct packed {
      logic [PRICE_W-1:0] price;
      logic [ID_W-1:0]    id;
      logic [QTY_W-1:0]   qty;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic               kind;
      logic [ID_W-1:0]    buy_id;
      logic [ID_W-1:0]    sell_id;
      logic [QTY_W-1:0]   trade_quantity;
      logic [PRICE_W-1:0] trade_price;
      logic [QTY_W-1:0]   rested_quantity;
      logic [1:0]         status;
      logic               last;
   } result_type;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_MRD  = 8'b0000_0010,
      ST_MCHK = 8'b0000_0100,
      ST_TRD  = 8'b0000_1000,
      ST_FIN  = 8'b0001_0000,
      ST_ICHK = 8'b0010_0000,
      ST_INEW = 8'b0100_0000,
      ST_SUM  = 8'b1000_0000
   } state_type;

   // Map a logical book position onto the circular RAM address.
   function automatic logic [AW-1:0] phys_addr(logic [AW-1:0] head, logic [CW-1:0] pos);
      logic [CW:0] sum;
      sum = {{(CW+1-AW){1'b0}}, head} + {1'b0, pos};
      if (sum >= (CW+1)'(BOOK_DEPTH)) begin
         sum = sum - (CW+1)'(BOOK_DEPTH);
      end
      return sum[AW-1:0];
   endfunction

endpackage

### sv/lobm_if.sv
// Handshake channel interfaces for order requests and match results.
// Depends on lobm_pkg.
interface lobm_req_if;
   import lobm_pkg::*;
   logic               valid;
   logic               ready;
   logic               operation;
   logic [ID_W-1:0]    order_id;
   logic [PRICE_W-1:0] limit_price;
   logic [QTY_W-1:0]   order_quantity;
   modport source (output valid, operation, order_id, limit_price, order_quantity,
                   input ready);
   modport sink   (input valid, operation, order_id, limit_price, order_quantity,
                   output ready);
endinterface

interface lobm_rsp_if;
   import lobm_pkg::*;
   logic               valid;
   logic               ready;
   logic               kind;
   logic [ID_W-1:0]    buy_id;
   logic [ID_W-1:0]    sell_id;
   logic [QTY_W-1:0]   trade_quantity;
   logic [PRICE_W-1:0] trade_price;
   logic [QTY_W-1:0]   rested_quantity;
   logic [1:0]         status;
   logic               last;
   modport source (output valid, kind, buy_id, sell_id, trade_quantity, trade_price,
                   rested_quantity, status, last, input ready);
   modport sink   (input valid, kind, buy_id, sell_id, trade_quantity, trade_price,
                   rested_quantity, status, last, output ready);
endinterface

### sv/limit_order_book_matcher.sv
// Limit order book matcher top level: sequencer around two book RAMs.
// Depends on lobm_pkg, lobm_if and lobm_ram.
//
// Takes one limit order per request transfer and works on it alone until its
// summary has been loaded into the result register. Bids and asks each live
// in a circular RAM of BOOK_DEPTH entries kept in price-time order, so the best
// entry sits at the side's head pointer and a filled resting order leaves by
// advancing the head. Matching visits each resting order with a RAM read, then
// a compare, then, if it crosses, a trade report; a remainder is inserted by
// walking from the tail, shifting one entry per step, and then placing it. A
// zero-quantity order goes straight to its summary. The result register lets a
// report wait for the sink while matching carries on. No clearing pass is
// needed: only entries below each side's count are ever read.
module limit_order_book_matcher (
   input  logic              clock,
   input  logic              reset,
   lobm_req_if.sink          req_bus,
   lobm_rsp_if.source        rsp_bus
);
   import lobm_pkg::*;

   state_type          state_ff, state_in;
   logic               op_ff, op_in;
   logic [ID_W-1:0]    oid_ff, oid_in;
   logic [PRICE_W-1:0] price_ff, price_in;
   logic [QTY_W-1:0]   qty_ff, qty_in;
   entry_type          front_ff, front_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [1:0]         sum_status_ff, sum_status_in;
   logic [QTY_W-1:0]   sum_rested_ff, sum_rested_in;
   logic [AW-1:0]      head_ff [2];
   logic [AW-1:0]      head_in [2];
   logic [CW-1:0]      count_ff [2];
   logic [CW-1:0]      count_in [2];
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_data_ff, rsp_data_in;

   logic               wr_en [2];
   logic [AW-1:0]      wr_addr [2];
   entry_type          wr_data [2];
   logic               rd_en [2];
   logic [AW-1:0]      rd_addr [2];
   logic [ENTRY_W-1:0] rd_data [2];

   logic               opp, own, out_free, crossed, good;
   logic [QTY_W-1:0]   fill;
   entry_type          opp_rd, own_rd, new_entry;

   lobm_ram #(.WIDTH(ENTRY_W), .DEPTH(BOOK_DEPTH)) u_bid_ram (
      .clock(clock), .wr_en(wr_en[SIDE_BID]), .wr_addr(wr_addr[SIDE_BID]),
      .wr_data(wr_data[SIDE_BID]), .rd_en(rd_en[SIDE_BID]),
      .rd_addr(rd_addr[SIDE_BID]), .rd_data(rd_data[SIDE_BID])
   );

   lobm_ram #(.WIDTH(ENTRY_W), .DEPTH(BOOK_DEPTH)) u_ask_ram (
      .clock(clock), .wr_en(wr_en[SIDE_ASK]), .wr_addr(wr_addr[SIDE_ASK]),
      .wr_data(wr_data[SIDE_ASK]), .rd_en(rd_en[SIDE_ASK]),
      .rd_addr(rd_addr[SIDE_ASK]), .rd_data(rd_data[SIDE_ASK])
   );

   // A sell rests among the asks and matches the bids; a buy the other way round.
   assign own      = (op_ff == OP_SELL) ? SIDE_ASK : SIDE_BID;
   assign opp      = ~own;
   assign opp_rd   = entry_type'(rd_data[opp]);
   assign own_rd   = entry_type'(rd_data[own]);
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign fill     = (qty_ff < front_ff.qty) ? qty_ff : front_ff.qty;
   assign crossed  = (op_ff == OP_SELL) ? (opp_rd.price >= price_ff)
                                        : (opp_rd.price <= price_ff);
   // Stop the tail walk at an entry at least as good: equal prices keep arrival order.
   assign good     = (op_ff == OP_SELL) ? (own_rd.price <= price_ff)
                                        : (own_rd.price >= price_ff);

   always_comb begin
      new_entry.price = price_ff;
      new_entry.id    = oid_ff;
      new_entry.qty   = qty_ff;
   end

   assign req_bus.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      oid_in        = oid_ff;
      price_in      = price_ff;
      qty_in        = qty_ff;
      front_in      = front_ff;
      idx_in        = idx_ff;
      sum_status_in = sum_status_ff;
      sum_rested_in = sum_rested_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_data_in   = rsp_data_ff;
      for (int s = 0; s < 2; s++) begin
         wr_en[s]   = 1'b0;
         wr_addr[s] = '0;
         wr_data[s] = '0;
         rd_en[s]   = 1'b0;
         rd_addr[s] = '0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               op_in    = req_bus.operation;
               oid_in   = req_bus.order_id;
               price_in = req_bus.limit_price;
               qty_in   = req_bus.order_quantity;
               if (req_bus.order_quantity == '0) begin
                  sum_status_in = STATUS_ZERO;
                  sum_rested_in = '0;
                  state_in      = ST_SUM;
               end else begin
                  state_in = ST_MRD;
               end
            end
         end
         ST_MRD: begin
            // Fetch the best opposite entry, if any.
            if (count_ff[opp] == '0) begin
               state_in = ST_FIN;
            end else begin
               rd_en[opp]   = 1'b1;
               rd_addr[opp] = head_ff[opp];
               state_in     = ST_MCHK;
            end
         end
         ST_MCHK: begin
            front_in = opp_rd;
            state_in = crossed ? ST_TRD : ST_FIN;
         end
         ST_TRD: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in                 = '0;
               rsp_data_in.kind            = KIND_TRADE;
               rsp_data_in.buy_id          = (op_ff == OP_SELL) ? front_ff.id : oid_ff;
               rsp_data_in.sell_id         = (op_ff == OP_SELL) ? oid_ff : front_ff.id;
               rsp_data_in.trade_quantity  = fill;
               rsp_data_in.trade_price     = (op_ff == OP_SELL) ? price_ff : front_ff.price;
               qty_in                      = qty_ff - fill;
               if (front_ff.qty == fill) begin
                  // Resting order used up: advance the head.
                  head_in[opp]  = (head_ff[opp] == AW'(BOOK_DEPTH - 1)) ? '0
                                                                        : head_ff[opp] + 1'b1;
                  count_in[opp] = count_ff[opp] - 1'b1;
                  state_in      = (qty_ff == fill) ? ST_FIN : ST_MRD;
               end else begin
                  // Incoming order used up: write back the reduced resting quantity.
                  wr_en[opp]       = 1'b1;
                  wr_addr[opp]     = head_ff[opp];
                  wr_data[opp]     = front_ff;
                  wr_data[opp].qty = front_ff.qty - fill;
                  state_in         = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            sum_rested_in = '0;
            sum_status_in = STATUS_OK;
            if (qty_ff == '0) begin
               state_in = ST_SUM;
            end else if (count_ff[own] >= CW'(BOOK_DEPTH)) begin
               sum_status_in = STATUS_FULL;
               state_in      = ST_SUM;
            end else if (count_ff[own] == '0) begin
               wr_en[own]    = 1'b1;
               wr_addr[own]  = head_ff[own];
               wr_data[own]  = new_entry;
               count_in[own] = count_ff[own] + 1'b1;
               sum_rested_in = qty_ff;
               state_in      = ST_SUM;
            end else begin
               idx_in       = count_ff[own];
               rd_en[own]   = 1'b1;
               rd_addr[own] = phys_addr(head_ff[own], count_ff[own] - 1'b1);
               state_in     = ST_ICHK;
            end
         end
         ST_ICHK: begin
            // Walk from the tail, shifting worse entries down by one.
            wr_en[own]   = 1'b1;
            wr_addr[own] = phys_addr(head_ff[own], idx_ff);
            if (good) begin
               wr_data[own]  = new_entry;
               count_in[own] = count_ff[own] + 1'b1;
               sum_rested_in = qty_ff;
               state_in      = ST_SUM;
            end else begin
               wr_data[own] = own_rd;
               idx_in       = idx_ff - 1'b1;
               if (idx_ff == CW'(1)) begin
                  state_in = ST_INEW;
               end else begin
                  rd_en[own]   = 1'b1;
                  rd_addr[own] = phys_addr(head_ff[own], idx_ff - CW'(2));
               end
            end
         end
         ST_INEW: begin
            wr_en[own]    = 1'b1;
            wr_addr[own]  = head_ff[own];
            wr_data[own]  = new_entry;
            count_in[own] = count_ff[own] + 1'b1;
            sum_rested_in = qty_ff;
            state_in      = ST_SUM;
         end
         ST_SUM: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in                 = '0;
               rsp_data_in.kind            = KIND_SUMMARY;
               rsp_data_in.rested_quantity = sum_rested_ff;
               rsp_data_in.status          = sum_status_ff;
               rsp_data_in.last            = 1'b1;
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '{default: '0};
         count_ff     <= '{default: '0};
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
      end
      op_ff         <= op_in;
      oid_ff        <= oid_in;
      price_ff      <= price_in;
      qty_ff        <= qty_in;
      front_ff      <= front_in;
      idx_ff        <= idx_in;
      sum_status_ff <= sum_status_in;
      sum_rested_ff <= sum_rested_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.kind            = rsp_data_ff.kind;
   assign rsp_bus.buy_id          = rsp_data_ff.buy_id;
   assign rsp_bus.sell_id         = rsp_data_ff.sell_id;
   assign rsp_bus.trade_quantity  = rsp_data_ff.trade_quantity;
   assign rsp_bus.trade_price     = rsp_data_ff.trade_price;
   assign rsp_bus.rested_quantity = rsp_data_ff.rested_quantity;
   assign rsp_bus.status          = rsp_data_ff.status;
   assign rsp_bus.last            = rsp_data_ff.last;
endmodule

### sv/lobm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lobm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### sim/lobm_tb_if.sv
`timescale 1ns / 1ps
// Testbench-side types for orders and resting entries, and the match scoreboard.
// Depends on lobm_pkg only.
package lobm_tb_pkg;
   import lobm_pkg::*;

   typedef struct {
      logic               side;
      logic [ID_W-1:0]    id;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   qty;
   } order_type;

   typedef struct {
      logic [PRICE_W-1:0] price;
      logic [ID_W-1:0]    id;
      logic [QTY_W-1:0]   qty;
   } resting_type;

   // Book shadow and pending match results.
   class match_scoreboard;
      resting_type bids[$];
      resting_type asks[$];
      result_type  pending[$];
      int          errors;

      // Append one expected result at the tail of the pending queue.
      function void expect_result(result_type r);
         pending.insert(pending.size(), r);
      endfunction

      function void note_order(order_type o);
         logic [QTY_W-1:0] left, fill;
         result_type r;
         int pos, trades;
         resting_type e;
         left = o.qty;
         trades = 0;
         if (left == 0) begin
            r = '0;
            r.kind = KIND_SUMMARY;
            r.status = STATUS_ZERO;
            r.last = 1'b1;
            expect_result(r);
            return;
         end
         if (o.side == OP_SELL) begin
            while (left > 0 && bids.size() > 0 && trades < BOOK_DEPTH &&
                   bids[0].price >= o.price) begin
               fill = (left < bids[0].qty) ? left : bids[0].qty;
               r = '0;
               r.kind = KIND_TRADE;
               r.buy_id = bids[0].id;
               r.sell_id = o.id;
               r.trade_quantity = fill;
               r.trade_price = o.price;
               expect_result(r);
               trades++;
               left -= fill;
               bids[0].qty -= fill;
               if (bids[0].qty == 0) void'(bids.pop_front());
            end
         end else begin
            while (left > 0 && asks.size() > 0 && trades < BOOK_DEPTH &&
                   asks[0].price <= o.price) begin
               fill = (left < asks[0].qty) ? left : asks[0].qty;
               r = '0;
               r.kind = KIND_TRADE;
               r.buy_id = o.id;
               r.sell_id = asks[0].id;
               r.trade_quantity = fill;
               r.trade_price = asks[0].price;
               expect_result(r);
               trades++;
               left -= fill;
               asks[0].qty -= fill;
               if (asks[0].qty == 0) void'(asks.pop_front());
            end
         end
         r = '0;
         r.kind = KIND_SUMMARY;
         r.last = 1'b1;
         e.price = o.price;
         e.id = o.id;
         e.qty = left;
         if (left == 0) begin
            r.status = STATUS_OK;
         end else if (o.side == OP_SELL) begin
            if (asks.size() >= BOOK_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               pos = 0;
               while (pos < asks.size() && asks[pos].price <= o.price) pos++;
               asks.insert(pos, e);
               r.rested_quantity = left;
            end
         end else begin
            if (bids.size() >= BOOK_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               pos = 0;
               while (pos < bids.size() && bids[pos].price >= o.price) pos++;
               bids.insert(pos, e);
               r.rested_quantity = left;
            end
         end
         expect_result(r);
      endfunction

      function void check_result(result_type got);
         result_type w;
         if (pending.size() == 0) begin
            $error("unexpected result kind=%0d", got.kind);
            errors++;
            return;
         end
         w = pending.pop_front();
         if (got.kind !== w.kind) begin
            $error("kind: expected %0d, got %0d", w.kind, got.kind); errors++;
         end
         if (got.buy_id !== w.buy_id) begin
            $error("buy_id: expected %0h, got %0h", w.buy_id, got.buy_id); errors++;
         end
         if (got.sell_id !== w.sell_id) begin
            $error("sell_id: expected %0h, got %0h", w.sell_id, got.sell_id); errors++;
         end
         if (got.trade_quantity !== w.trade_quantity) begin
            $error("trade_quantity: expected %0d, got %0d", w.trade_quantity,
                   got.trade_quantity);
            errors++;
         end
         if (got.trade_price !== w.trade_price) begin
            $error("trade_price: expected %0d, got %0d", w.trade_price, got.trade_price);
            errors++;
         end
         if (got.rested_quantity !== w.rested_quantity) begin
            $error("rested_quantity: expected %0d, got %0d", w.rested_quantity,
                   got.rested_quantity);
            errors++;
         end
         if (got.status !== w.status) begin
            $error("status: expected %0d, got %0d", w.status, got.status); errors++;
         end
         if (got.last !== w.last) begin
            $error("last: expected %0d, got %0d", w.last, got.last); errors++;
         end
      endfunction
   endclass
endpackage

### sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for limit_order_book_matcher: random and directed orders.
// Depends on lobm_pkg, lobm_if, lobm_tb_pkg and the RTL.
module testbench;
   import lobm_pkg::*;
   import lobm_tb_pkg::*;

   logic clock;
   logic reset;
   logic rsp_hold;      // long receiver hold-off, set by the stimulus process

   lobm_req_if req_bus ();
   lobm_rsp_if rsp_bus ();

   match_scoreboard book_check;

   limit_order_book_matcher dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop: worst case far below this.
   initial begin
      #20ms;
      $display("limit_order_book_matcher test failed");
      $finish;
   end

   // Present one order at the falling edge and hold it until the transfer.
   // Valid stays high after the transfer; a gap before the next order or wait_drained drops it.
   task automatic send_order(logic side, logic [ID_W-1:0] id,
                             logic [PRICE_W-1:0] price, logic [QTY_W-1:0] qty,
                             bit no_gap = 0);
      int gap;
      order_type o;
      gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13));
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.operation      <= side;
      req_bus.order_id       <= id;
      req_bus.limit_price    <= price;
      req_bus.order_quantity <= qty;
      o.side = side;
      o.id = id;
      o.price = price;
      o.qty = qty;
      do @(posedge clock); while (!req_bus.ready);
      book_check.note_order(o);
      @(negedge clock);
   endtask

   // Prices cluster near a mid so the books cross often.
   task automatic send_random(int n);
      logic [PRICE_W-1:0] p;
      logic [QTY_W-1:0] q;
      repeat (n) begin
         p = PRICE_W'(32'd4980 + $urandom_range(0, 40));
         case ($urandom_range(0, 9))
            0:       q = QTY_W'($urandom);
            1:       q = 16'd0;
            default: q = QTY_W'($urandom_range(1, 300));
         endcase
         if ($urandom_range(0, 19) == 0) p = PRICE_W'($urandom);
         send_order(1'($urandom_range(0, 1)), ID_W'($urandom), p, q);
      end
   endtask

   // Drop valid and hold until every expected result has arrived.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (book_check.pending.size() != 0) @(negedge clock);
   endtask

   // Receiver: random stall per result, unless held off.
   initial begin
      int stall;
      result_type got;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold) begin
            rsp_bus.ready <= 1'b0;
         end else begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
            rsp_bus.ready <= 1'b1;
            do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
            got.kind            = rsp_bus.kind;
            got.buy_id          = rsp_bus.buy_id;
            got.sell_id         = rsp_bus.sell_id;
            got.trade_quantity  = rsp_bus.trade_quantity;
            got.trade_price     = rsp_bus.trade_price;
            got.rested_quantity = rsp_bus.rested_quantity;
            got.status          = rsp_bus.status;
            got.last            = rsp_bus.last;
            book_check.check_result(got);
         end
      end
   end

   // Stimulus and final verdict.
   initial begin
      int i;
      book_check = new();
      reset = 1'b1;
      rsp_hold = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.operation = OP_BUY;
      req_bus.order_id = '0;
      req_bus.limit_price = '0;
      req_bus.order_quantity = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: zero quantity, field extremes, a full fill, partial sweep.
      send_order(OP_BUY, 32'hFFFF_FFFF, 20'hFFFFF, 16'd0);
      send_order(OP_SELL, 32'd0, 20'd0, 16'd0);
      send_order(OP_BUY, 32'h5555_5555, 20'd100, 16'hFFFF);
      send_order(OP_BUY, 32'hAAAA_AAAA, 20'd100, 16'd10);  // same price, later
      send_order(OP_SELL, 32'h0000_0001, 20'd0, 16'hFFFF); // fills the earlier bid only
      send_order(OP_SELL, 32'h0000_0002, 20'hFFFFF, 16'hFFFF);
      send_order(OP_BUY, 32'h0000_0003, 20'hFFFFF, 16'd5);
      send_order(OP_BUY, 32'h0000_0004, 20'hFFFFF, 16'hFFFF); // full fill then rest
      send_order(OP_SELL, 32'h0000_0005, 20'd1, 16'd1);
      wait_drained();

      // Fill the bid side past depth so a remainder is dropped, then sweep it.
      for (i = 0; i < BOOK_DEPTH + 2; i++)
         send_order(OP_BUY, ID_W'(32'h100 + i), PRICE_W'(200 + (i % 7)), 16'd2);
      send_order(OP_SELL, 32'h0000_0900, 20'd0, 16'hFFFF); // 32 trades max
      wait_drained();

      // Long receiver hold-off while orders keep coming: input must stall.
      rsp_hold = 1'b1;
      fork
         begin
            repeat (400) @(negedge clock);
            rsp_hold = 1'b0;
         end
         send_random(20);
      join
      wait_drained();
      send_random(40);
      wait_drained();          // sender pause until all results are in
      send_random(80);

      req_bus.valid <= 1'b0;
      i = 0;
      while (book_check.pending.size() != 0 && i < 200000) begin
         @(negedge clock);
         i++;
      end
      repeat (50) @(negedge clock);
      if (book_check.errors == 0 && book_check.pending.size() == 0) begin
         $display("limit_order_book_matcher test passed");
      end else begin
         $display("limit_order_book_matcher test failed");
      end
      $finish;
   end
endmodule
